FILE: sv/shared_line_frame_receiver_unit_defines.svh
// Assertion macros shared by the verification files of the frame receiver.
// Depends on nothing; included by the port checker.
`ifndef SHARED_LINE_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SHARED_LINE_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLFR_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("slfr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLFR_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("slfr: next-cycle check failed");

`endif

FILE: sv/slfr_pkg.sv
// Types and constants of the shared line frame receiver.
// Used by the receive core, the top level and the port checker.
package slfr_pkg;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_BUSY = 2'd1;
    localparam logic [1:0] KIND_FREE = 2'd2;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_SEND     = 2'd1;
    localparam logic [1:0] MODE_ANNOUNCE = 2'd2;

    localparam logic [1:0] CFG_NODE_ADDR  = 2'd0;
    localparam logic [1:0] CFG_BCAST_ADDR = 2'd1;
    localparam logic [1:0] CFG_ANN_MASK   = 2'd2;
    localparam logic [1:0] CFG_NAK_MASK   = 2'd3;

    localparam logic [7:0] NODE_ADDR_RST  = 8'd0;
    localparam logic [7:0] BCAST_ADDR_RST = 8'd255;
    localparam logic [7:0] ANN_MASK_RST   = 8'd128;
    localparam logic [7:0] NAK_MASK_RST   = 8'd64;

    localparam int MIN_FRAME = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [1:0] local_mode;
    } in_t;

    typedef struct packed {
        logic       is_tx_byte;
        logic [7:0] tx_byte;
        logic       last;
        logic       packet_waiting;
        logic [5:0] frame_length;
        logic       checksum_ok;
    } out_t;

    typedef struct packed {
        logic       packet_waiting;
        logic [5:0] frame_length;
        logic       checksum_ok;
    } slfr_status_t;

endpackage

FILE: sv/slfr_rx_core.sv
// Frame state of the receiver: byte count, running sum, header and tail bytes.
// Depends on slfr_pkg; instantiated by the top level.
module slfr_rx_core #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  slfr_pkg::in_t         item,
    input  logic [7:0]            node_addr,
    input  logic [7:0]            bcast_addr,
    input  logic [7:0]            ann_mask,
    output logic                  send_nak,
    output slfr_pkg::slfr_status_t status
);
    import slfr_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BYTES + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       sum_reg, sum_next;
    logic             wait_reg, wait_next;
    // Only the three header bytes and the newest byte are ever inspected.
    logic [7:0]       hdr0_reg, hdr1_reg, hdr2_reg, tail_reg;

    logic store_en, busy_clr, frame_ok, is_bcast, sum_ok;

    always_comb
    begin
        sum_ok   = (cnt_reg != '0) && ((sum_reg - tail_reg) == tail_reg);
        store_en = (item.kind == KIND_BYTE) && (item.local_mode != MODE_SEND)
                   && (cnt_reg < CNT_W'(FRAME_BYTES));
        busy_clr = (item.kind == KIND_BUSY) && (item.local_mode != MODE_SEND);
        frame_ok = (item.kind == KIND_FREE) && (item.local_mode != MODE_ANNOUNCE)
                   && (cnt_reg >= CNT_W'(MIN_FRAME)) && sum_ok;
        is_bcast = (hdr0_reg == bcast_addr);
        send_nak = step_en && frame_ok && is_bcast
                   && ((hdr2_reg & ann_mask) != 8'd0) && (hdr1_reg == node_addr);

        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        wait_next = wait_reg;
        if (store_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            sum_next = sum_reg + item.rx_byte;
        end
        else if (busy_clr)
        begin
            cnt_next  = '0;
            sum_next  = 8'd0;
            wait_next = 1'b0;
        end
        else if (send_nak)
        begin
            cnt_next = '0;
            sum_next = 8'd0;
        end
        else if (frame_ok && !is_bcast && (hdr0_reg == node_addr))
        begin
            wait_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sum_reg  <= 8'd0;
            wait_reg <= 1'b0;
        end
        else if (step_en)
        begin
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
            wait_reg <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && store_en)
        begin
            tail_reg <= item.rx_byte;
            if (cnt_reg == CNT_W'(0))
                hdr0_reg <= item.rx_byte;
            if (cnt_reg == CNT_W'(1))
                hdr1_reg <= item.rx_byte;
            if (cnt_reg == CNT_W'(2))
                hdr2_reg <= item.rx_byte;
        end
    end

    assign status.packet_waiting = wait_reg;
    assign status.frame_length   = 6'(cnt_reg);
    assign status.checksum_ok    = sum_ok;

endmodule

FILE: sv/shared_line_frame_receiver_unit.sv
// Top level of the shared line frame receiver: handshakes, configuration
// registers and the result stage. Depends on slfr_pkg and slfr_rx_core.
//
// Usage: each input beat on in_valid/in_ready carries one line event (a
// received byte, the line going busy, or the line going free) plus the node's
// current activity. Every event yields one result beat on out_valid/out_ready
// holding the frame status after the event; a free edge that ends a valid
// announce claiming this node's address yields four beats carrying the NAK
// frame, with last set on the fourth.
// The first result beat is registered and valid in the cycle after the input beat.
// Throughput: one event per cycle while results are taken at once; a NAK
// event occupies the result stage for its four NAK bytes, one beat per byte.
// The result register frees up on the cycle its final beat is taken, so a new
// input beat is accepted in that same cycle. A stalled receiver holds the
// result and blocks further input beats until the final beat goes out.
// Configuration beats (cfg_valid/cfg_ready) are always taken at once: cfg_ready is tied high.
// Reset clears the frame, the waiting flag and the result stage, and loads
// the register defaults: node 0, broadcast 255, announce mask 128, NAK 64.
module shared_line_frame_receiver_unit #(
    parameter int FRAME_BYTES = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  slfr_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output slfr_pkg::out_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data
);
    import slfr_pkg::*;

    logic [7:0] node_addr_reg, bcast_addr_reg, ann_mask_reg, nak_mask_reg;

    logic       out_valid_reg, out_valid_next;
    logic       nak_reg, nak_next;
    logic [1:0] beat_reg, beat_next;

    logic         step_en, send_nak, out_last, out_take;
    slfr_status_t status;
    logic [7:0]   nak_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_addr_reg  <= NODE_ADDR_RST;
            bcast_addr_reg <= BCAST_ADDR_RST;
            ann_mask_reg   <= ANN_MASK_RST;
            nak_mask_reg   <= NAK_MASK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NODE_ADDR:  node_addr_reg  <= cfg_data;
                CFG_BCAST_ADDR: bcast_addr_reg <= cfg_data;
                CFG_ANN_MASK:   ann_mask_reg   <= cfg_data;
                CFG_NAK_MASK:   nak_mask_reg   <= cfg_data;
                default:        node_addr_reg  <= node_addr_reg;
            endcase
        end
    end

    slfr_rx_core #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .item      (in_data),
        .node_addr (node_addr_reg),
        .bcast_addr(bcast_addr_reg),
        .ann_mask  (ann_mask_reg),
        .send_nak  (send_nak),
        .status    (status)
    );

    assign out_last = !nak_reg || (beat_reg == 2'd3);
    assign out_take = out_valid_reg && out_ready;
    assign in_ready = !out_valid_reg || (out_ready && out_last);
    assign step_en  = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        nak_next       = nak_reg;
        beat_next      = beat_reg;
        if (step_en)
        begin
            out_valid_next = 1'b1;
            nak_next       = send_nak;
            beat_next      = 2'd0;
        end
        else if (out_take)
        begin
            if (out_last)
                out_valid_next = 1'b0;
            else
                beat_next = beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            nak_reg       <= 1'b0;
            beat_reg      <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            nak_reg       <= nak_next;
            beat_reg      <= beat_next;
        end
    end

    // The user must keep the configuration stable while a NAK frame is going out
    // (the block does not enforce it), as its bytes come straight from the registers.
    always_comb
    begin
        case (beat_reg)
            2'd0:    nak_byte = bcast_addr_reg;
            2'd1:    nak_byte = node_addr_reg;
            2'd2:    nak_byte = nak_mask_reg;
            default: nak_byte = bcast_addr_reg + node_addr_reg + nak_mask_reg;
        endcase
    end

    assign out_valid               = out_valid_reg;
    assign out_data.is_tx_byte     = nak_reg;
    assign out_data.tx_byte        = nak_reg ? nak_byte : 8'd0;
    assign out_data.last           = out_last;
    assign out_data.packet_waiting = status.packet_waiting;
    assign out_data.frame_length   = status.frame_length;
    assign out_data.checksum_ok    = status.checksum_ok;

endmodule

FILE: sv/slfr_checker.sv
// Port-level checks of the frame receiver, bound to the top level.
// Depends on slfr_pkg and shared_line_frame_receiver_unit_defines.svh.
`include "shared_line_frame_receiver_unit_defines.svh"

module slfr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input slfr_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input slfr_pkg::out_t out_data
);
    import slfr_pkg::*;

    // A stalled result beat stays put.
    `SLFR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // A NAK frame is never cut short.
    `SLFR_ASSERT_NXT(a_nak_burst, clk, rst_n, out_valid && out_ready && out_data.is_tx_byte && !out_data.last, out_valid && out_data.is_tx_byte)

    // A status-only result is a single beat with no byte to send.
    `SLFR_ASSERT_IMP(a_status_beat, clk, rst_n, out_valid && !out_data.is_tx_byte, out_data.last && (out_data.tx_byte == 8'd0))

    // A busy edge seen while idle shows an empty frame and no waiting packet.
    `SLFR_ASSERT_NXT(a_busy_clear, clk, rst_n, in_valid && in_ready && (in_data.kind == KIND_BUSY) && (in_data.local_mode == MODE_IDLE), out_valid && (out_data.frame_length == 6'd0) && !out_data.packet_waiting)

endmodule

bind shared_line_frame_receiver_unit slfr_checker u_slfr_checker (.*);

FILE: test/shared_line_frame_receiver_unit_test.sv
// Self-checking bench for the shared line frame receiver: directed line events,
// then random frames under several register settings. Depends on slfr_pkg.
module shared_line_frame_receiver_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import slfr_pkg::*;

    localparam int FRAME_BYTES   = 32;
    localparam int DIRECTED_ROWS = 25;
    localparam int PHASE_ITEMS   = 46;
    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 3000;

    // Codes the package leaves unnamed: the spare event and the spare mode.
    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Status beats that can be read off at a glance.
    localparam out_t ST_EMPTY  = '{1'b0, 8'h00, 1'b1, 1'b0, 6'd0, 1'b0};
    localparam out_t ST_ONE_OK = '{1'b0, 8'h00, 1'b1, 1'b0, 6'd1, 1'b1};

    typedef struct {
        in_t  ev;
        bit   typed;
        out_t want;
    } plan_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_t        in_data;
    logic       out_valid;
    logic       out_ready;
    out_t       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // Shadow of the receiver state and its registers.
    logic [7:0] rx_frame [FRAME_BYTES];
    int         rx_count;
    logic [7:0] rx_sum;
    logic       pkt_wait;
    logic [7:0] cfg_node;
    logic [7:0] cfg_bcast;
    logic [7:0] cfg_ann;
    logic [7:0] cfg_nak;

    out_t       step_beats [$];
    out_t       expected_beats [$];
    plan_row_t  plan [DIRECTED_ROWS];

    int         mismatch_count;
    int         items_sent;
    int         quiet_cycles;
    int         send_gap_odds;
    int         take_gap_odds;
    bit         hold_req;

    shared_line_frame_receiver_unit #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic tail_matches();
        logic [7:0] tail;
        if (rx_count == 0 || rx_count > FRAME_BYTES)
            return 1'b0;
        tail = rx_frame[rx_count - 1];
        return 8'(rx_sum - tail) == tail;
    endfunction

    function automatic out_t status_beat(logic is_tx, logic [7:0] tx, logic fin);
        return '{is_tx, tx, fin, pkt_wait, 6'(rx_count), tail_matches()};
    endfunction

    // Advances the shadow state by one line event and leaves its beats in step_beats.
    function automatic void predict_line_event(in_t ev);
        logic       nak;
        logic [7:0] nak_frame [4];
        int         i;
        nak = 1'b0;
        step_beats.delete();
        case (ev.kind)
            KIND_BYTE:
                if (ev.local_mode != MODE_SEND && rx_count < FRAME_BYTES)
                begin
                    rx_frame[rx_count] = ev.rx_byte;
                    rx_count++;
                    rx_sum = rx_sum + ev.rx_byte;
                end
            KIND_BUSY:
                if (ev.local_mode != MODE_SEND)
                begin
                    rx_count = 0;
                    rx_sum   = 8'h00;
                    pkt_wait = 1'b0;
                end
            KIND_FREE:
                if (ev.local_mode != MODE_ANNOUNCE && rx_count >= MIN_FRAME && tail_matches())
                begin
                    // The broadcast test wins even when the node owns that address.
                    if (rx_frame[0] == cfg_bcast)
                    begin
                        if ((rx_frame[2] & cfg_ann) != 8'h00 && rx_frame[1] == cfg_node)
                        begin
                            nak      = 1'b1;
                            rx_count = 0;
                            rx_sum   = 8'h00;
                        end
                    end
                    else if (rx_frame[0] == cfg_node)
                        pkt_wait = 1'b1;
                end
            default: ;
        endcase
        if (nak)
        begin
            nak_frame = '{cfg_bcast, cfg_node, cfg_nak, 8'(cfg_bcast + cfg_node + cfg_nak)};
            for (i = 0; i < 4; i++)
                step_beats.push_back(status_beat(1'b1, nak_frame[i], i == 3));
        end
        else
            step_beats.push_back(status_beat(1'b0, 8'h00, 1'b1));
    endfunction

    function automatic in_t line_event(logic [1:0] k, logic [7:0] b, logic [1:0] m);
        return '{k, b, m};
    endfunction

    // Mostly idle, now and then one of the other activities.
    function automatic logic [1:0] rare_mode(int odds);
        if ($urandom_range(0, odds - 1) != 0)
            return MODE_IDLE;
        case ($urandom_range(0, 2))
            0: return MODE_SEND;
            1: return MODE_ANNOUNCE;
            default: return MODE_SPARE;
        endcase
    endfunction

    task automatic send_event(input in_t ev, input bit typed = 1'b0, input out_t want = '0);
        int i;
        if (send_gap_odds != 0 && $urandom_range(0, send_gap_odds - 1) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_data  <= ev;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_line_event(ev);
        if (typed)
            expected_beats.push_back(want);
        else
            for (i = 0; i < step_beats.size(); i++)
                expected_beats.push_back(step_beats[i]);
        items_sent++;
    endtask

    // Stops offering events until every expected beat has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_registers(input logic [7:0] node, input logic [7:0] bcast,
                                  input logic [7:0] ann, input logic [7:0] nak);
        logic [1:0] regs [4] = '{CFG_NODE_ADDR, CFG_BCAST_ADDR, CFG_ANN_MASK, CFG_NAK_MASK};
        logic [7:0] vals [4];
        int         i;
        vals = '{node, bcast, ann, nak};
        for (i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            case (regs[i])
                CFG_NODE_ADDR:  cfg_node  = vals[i];
                CFG_BCAST_ADDR: cfg_bcast = vals[i];
                CFG_ANN_MASK:   cfg_ann   = vals[i];
                default:        cfg_nak   = vals[i];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // One frame between a busy edge and a free edge, shaped to reach the
    // claim, the addressed frame, short, overlong and corrupted cases.
    task automatic send_frame();
        logic [7:0] fb [36];
        logic [7:0] acc;
        int         n;
        int         shape;
        int         stored;
        int         i;
        shape = $urandom_range(0, 9);
        if (shape == 7)
            n = $urandom_range(1, 3);
        else if (shape == 8)
            n = $urandom_range(FRAME_BYTES + 1, 36);
        else if ($urandom_range(0, 7) == 0)
            n = $urandom_range(11, FRAME_BYTES);
        else
            n = $urandom_range(MIN_FRAME, 10);
        for (i = 0; i < n; i++)
            fb[i] = 8'($urandom);
        case (shape)
            0, 1, 2:
            begin
                fb[0] = cfg_bcast;
                fb[1] = cfg_node;
                fb[2] = fb[2] | (cfg_ann & 8'($urandom));
            end
            3, 4: fb[0] = cfg_node;
            5: fb[0] = cfg_bcast;
            default: ;
        endcase
        // Bytes past the frame limit are dropped, so the checksum sits on the
        // last byte that is actually stored.
        stored = (n > FRAME_BYTES) ? FRAME_BYTES : n;
        acc = 8'h00;
        for (i = 0; i < stored - 1; i++)
            acc = acc + fb[i];
        fb[stored - 1] = (shape == 9) ? (acc ^ (8'h01 << $urandom_range(0, 7))) : acc;

        if ($urandom_range(0, 9) != 0)
            send_event(line_event(KIND_BUSY, 8'($urandom), rare_mode(6)));
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_event(line_event(KIND_NONE, 8'($urandom), 2'($urandom)));
            send_event(line_event(KIND_BYTE, fb[i], rare_mode(12)));
        end
        send_event(line_event(KIND_FREE, 8'($urandom), rare_mode(4)));
        if ($urandom_range(0, 7) == 0)
            send_event(line_event(KIND_FREE, 8'($urandom), MODE_IDLE));
    endtask

    // Receiver side: random stalls, and one long hold-off on request.
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (take_gap_odds != 0 && $urandom_range(0, take_gap_odds - 1) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected: %h", out_data);
                mismatch_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (out_data.is_tx_byte !== want.is_tx_byte)
                begin
                    $error("is_tx_byte expected %0d got %0d",
                           want.is_tx_byte, out_data.is_tx_byte);
                    mismatch_count++;
                end
                if (out_data.tx_byte !== want.tx_byte)
                begin
                    $error("tx_byte expected %0d got %0d", want.tx_byte, out_data.tx_byte);
                    mismatch_count++;
                end
                if (out_data.last !== want.last)
                begin
                    $error("last expected %0d got %0d", want.last, out_data.last);
                    mismatch_count++;
                end
                if (out_data.packet_waiting !== want.packet_waiting)
                begin
                    $error("packet_waiting expected %0d got %0d",
                           want.packet_waiting, out_data.packet_waiting);
                    mismatch_count++;
                end
                if (out_data.frame_length !== want.frame_length)
                begin
                    $error("frame_length expected %0d got %0d",
                           want.frame_length, out_data.frame_length);
                    mismatch_count++;
                end
                if (out_data.checksum_ok !== want.checksum_ok)
                begin
                    $error("checksum_ok expected %0d got %0d",
                           want.checksum_ok, out_data.checksum_ok);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when no beat moves on any channel for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int  p;
        int  r;
        bit  paused;
        logic [7:0] v;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_NODE_ADDR;
        cfg_data  <= 8'h00;

        mismatch_count = 0;
        items_sent     = 0;
        hold_req       = 1'b0;
        send_gap_odds  = 5;
        take_gap_odds  = 5;
        rx_count       = 0;
        rx_sum         = 8'h00;
        pkt_wait       = 1'b0;
        cfg_node       = NODE_ADDR_RST;
        cfg_bcast      = BCAST_ADDR_RST;
        cfg_ann        = ANN_MASK_RST;
        cfg_nak        = NAK_MASK_RST;
        for (r = 0; r < FRAME_BYTES; r++)
            rx_frame[r] = 8'h00;

        plan = '{
            // Spare event and empty free edge right after reset.
            '{'{KIND_NONE, 8'hA5, MODE_IDLE},     1'b1, ST_EMPTY},
            '{'{KIND_FREE, 8'h00, MODE_IDLE},     1'b1, ST_EMPTY},
            // Own traffic is not stored.
            '{'{KIND_BYTE, 8'hFF, MODE_SEND},     1'b1, ST_EMPTY},
            '{'{KIND_BYTE, 8'h00, MODE_IDLE},     1'b1, ST_ONE_OK},
            // Short frame is ignored and a busy edge while sending keeps it.
            '{'{KIND_FREE, 8'hFF, MODE_IDLE},     1'b1, ST_ONE_OK},
            '{'{KIND_BUSY, 8'h00, MODE_SEND},     1'b1, ST_ONE_OK},
            '{'{KIND_BUSY, 8'hFF, MODE_IDLE},     1'b1, ST_EMPTY},
            // Broadcast announce claiming address 0.
            '{'{KIND_BYTE, 8'hFF, MODE_IDLE},     1'b0, '0},
            '{'{KIND_BYTE, 8'h00, MODE_IDLE},     1'b0, '0},
            '{'{KIND_BYTE, 8'h80, MODE_IDLE},     1'b0, '0},
            '{'{KIND_BYTE, 8'h7F, MODE_IDLE},     1'b0, '0},
            '{'{KIND_FREE, 8'h00, MODE_ANNOUNCE}, 1'b0, '0},
            '{'{KIND_FREE, 8'h00, MODE_SPARE},    1'b0, '0},
            // Frame addressed to this node.
            '{'{KIND_BUSY, 8'h00, MODE_SPARE},    1'b0, '0},
            '{'{KIND_BYTE, 8'h00, MODE_IDLE},     1'b0, '0},
            '{'{KIND_BYTE, 8'h12, MODE_SPARE},    1'b0, '0},
            '{'{KIND_BYTE, 8'h34, MODE_IDLE},     1'b0, '0},
            '{'{KIND_BYTE, 8'h46, MODE_IDLE},     1'b0, '0},
            '{'{KIND_FREE, 8'h00, MODE_IDLE},     1'b0, '0},
            // Broadcast that claims another address.
            '{'{KIND_BUSY, 8'h00, MODE_IDLE},     1'b0, '0},
            '{'{KIND_BYTE, 8'hFF, MODE_IDLE},     1'b0, '0},
            '{'{KIND_BYTE, 8'h05, MODE_IDLE},     1'b0, '0},
            '{'{KIND_BYTE, 8'h80, MODE_IDLE},     1'b0, '0},
            '{'{KIND_BYTE, 8'h84, MODE_IDLE},     1'b0, '0},
            '{'{KIND_FREE, 8'h00, MODE_IDLE},     1'b0, '0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIRECTED_ROWS; r++)
            send_event(plan[r].ev, plan[r].typed, plan[r].want);

        for (p = 0; p < 6; p++)
        begin
            drain();
            case (p)
                0: load_registers(8'h00, 8'hFF, 8'hFF, 8'h00);
                1: load_registers(8'hFF, 8'h00, 8'h01, 8'hFF);
                2:
                begin
                    // Node address equal to the broadcast address.
                    v = 8'($urandom);
                    load_registers(v, v, 8'($urandom_range(1, 255)), 8'($urandom));
                end
                4: load_registers(8'($urandom), 8'($urandom), 8'h00, 8'($urandom));
                default: load_registers(8'($urandom), 8'($urandom),
                                        8'($urandom_range(1, 255)), 8'($urandom));
            endcase
            case (p)
                0: begin send_gap_odds = 4; take_gap_odds = 4; end
                1: begin send_gap_odds = 0; take_gap_odds = 0; end
                2: begin send_gap_odds = 3; take_gap_odds = 6; hold_req = 1'b1; end
                3: begin send_gap_odds = 8; take_gap_odds = 2; end
                4: begin send_gap_odds = 5; take_gap_odds = 5; end
                default: begin send_gap_odds = 0; take_gap_odds = 0; end
            endcase
            items_sent = 0;
            paused = 1'b0;
            while (items_sent < PHASE_ITEMS)
            begin
                send_frame();
                if (p == 3 && !paused && items_sent > PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
